// ===== rtl/mpf_pkg.sv =====
// Shared types and constants for the MQTT PUBLISH framer.
// Used by mpf_encode, mqtt_publish_framer, the checker and the testbench; depends on nothing else.
package mpf_pkg;

  localparam logic [7:0] PublishType = 8'h30;
  localparam int unsigned VarintBase = 128;
  localparam int unsigned BurstMax = 8;
  localparam int unsigned CntW = $clog2(BurstMax + 1);
  localparam int unsigned RemW = 18;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_DATA  = 1'b1
  } action_t;

  typedef struct packed {
    logic [15:0] packet_ident;
    logic [15:0] topic_left;
    logic [15:0] message_left;
    logic        ident_pending;
  } frame_state_t;

  typedef struct packed {
    logic                    action;
    logic [15:0]             topic_length;
    logic [15:0]             message_length;
    logic [1:0]              qos;
    logic [7:0]              data_byte;
  } item_t;

  typedef struct packed {
    logic [BurstMax-1:0][7:0] bytes;
    logic [BurstMax-1:0]      last;
    logic [CntW-1:0]          count;
  } burst_t;

endpackage

// ===== rtl/mpf_encode.sv =====
// Combinational encoder: turns one input word and the framing state into
// the burst of packet bytes it causes and the next framing state. Uses mpf_pkg.
module mpf_encode (
  input  mpf_pkg::item_t        item,
  input  mpf_pkg::frame_state_t st,
  output mpf_pkg::frame_state_t st_nxt,
  output mpf_pkg::burst_t       burst
);
  import mpf_pkg::*;

  logic [1:0]      qos_eff;
  logic [RemW-1:0] rem;
  logic [1:0]      nv;
  logic [2:0]      pos;
  logic            has_ident;
  logic            tail;
  logic [15:0]     topic_dec;

  always_comb begin
    qos_eff   = (item.qos == 2'd3) ? 2'd2 : item.qos;
    has_ident = (qos_eff != 2'd0);
    rem       = RemW'(2) + RemW'(item.topic_length) + RemW'(item.message_length)
                + (has_ident ? RemW'(2) : RemW'(0));
    if (rem < RemW'(VarintBase)) begin
      nv = 2'd1;
    end else if (rem < RemW'(VarintBase * VarintBase)) begin
      nv = 2'd2;
    end else begin
      nv = 2'd3;
    end
    pos       = 3'd1 + 3'(nv);
    tail      = (item.topic_length == 16'd0) && !has_ident && (item.message_length == 16'd0);
    topic_dec = st.topic_left - 16'd1;

    st_nxt = st;
    burst  = '0;

    case (item.action)
      ACT_START: begin
        st_nxt.topic_left    = item.topic_length;
        st_nxt.message_left  = item.message_length;
        st_nxt.ident_pending = has_ident;
        burst.bytes[0] = PublishType | {5'd0, qos_eff, 1'b0};
        burst.bytes[1] = {(nv > 2'd1), rem[6:0]};
        burst.bytes[2] = {(nv > 2'd2), rem[13:7]};
        burst.bytes[3] = {4'd0, rem[17:14]};
        burst.bytes[pos]        = item.topic_length[15:8];
        burst.bytes[pos + 3'd1] = item.topic_length[7:0];
        burst.last[pos + 3'd1]  = tail;
        burst.count = CntW'(pos) + CntW'(2);
        if ((item.topic_length == 16'd0) && has_ident) begin
          burst.bytes[pos + 3'd2] = st.packet_ident[15:8];
          burst.bytes[pos + 3'd3] = st.packet_ident[7:0];
          burst.last[pos + 3'd3]  = (item.message_length == 16'd0);
          burst.count = CntW'(pos) + CntW'(4);
          st_nxt.packet_ident  = st.packet_ident + 16'd1;
          st_nxt.ident_pending = 1'b0;
        end
      end
      default: begin
        if (st.topic_left != 16'd0) begin
          st_nxt.topic_left = topic_dec;
          burst.bytes[0] = item.data_byte;
          burst.last[0]  = (topic_dec == 16'd0) && !st.ident_pending
                           && (st.message_left == 16'd0);
          burst.count = CntW'(1);
          if ((topic_dec == 16'd0) && st.ident_pending) begin
            burst.bytes[1] = st.packet_ident[15:8];
            burst.bytes[2] = st.packet_ident[7:0];
            burst.last[2]  = (st.message_left == 16'd0);
            burst.count = CntW'(3);
            st_nxt.packet_ident  = st.packet_ident + 16'd1;
            st_nxt.ident_pending = 1'b0;
          end
        end else if (st.message_left != 16'd0) begin
          st_nxt.message_left = st.message_left - 16'd1;
          burst.bytes[0] = item.data_byte;
          burst.last[0]  = (st.message_left == 16'd1);
          burst.count = CntW'(1);
        end
      end
    endcase
  end

endmodule

// ===== rtl/mqtt_publish_framer.sv =====
// MQTT PUBLISH framer top level: framing state, burst buffer and output register.
// An accepted word's bytes go to the burst buffer, then one by one to the output register.
// Throughput: one data word per cycle unless out_stall holds; a start word yields 4 to 8
// bytes, one per unstalled cycle from the output register; an ident-inserting word yields 3.
// Reset (synchronous, rst_n low) clears identifier, counters and all valid state.
module mqtt_publish_framer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [15:0] in_topic_length,
  input  logic [15:0] in_message_length,
  input  logic [1:0]  in_qos,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last
);
  import mpf_pkg::*;

  frame_state_t st_r, st_nxt, enc_st;
  burst_t       burst_r, burst_nxt, enc_burst;
  item_t        item;
  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   out_byte_r, out_byte_nxt;
  logic         out_last_r, out_last_nxt;
  logic         out_load, pop, in_acc;

  assign item = '{action: in_action, topic_length: in_topic_length,
                  message_length: in_message_length, qos: in_qos,
                  data_byte: in_data_byte};

  mpf_encode u_encode (
    .item   (item),
    .st     (st_r),
    .st_nxt (enc_st),
    .burst  (enc_burst)
  );

  assign out_load = !out_valid_r || !out_stall;
  assign pop      = (burst_r.count != '0) && out_load;
  assign in_stall = !((burst_r.count == '0) || ((burst_r.count == CntW'(1)) && pop));
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    st_nxt        = in_acc ? enc_st : st_r;
    burst_nxt     = burst_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = (burst_r.count != '0);
      out_byte_nxt  = burst_r.bytes[0];
      out_last_nxt  = burst_r.last[0];
    end
    if (in_acc) begin
      burst_nxt = enc_burst;
    end else if (pop) begin
      burst_nxt.bytes = burst_r.bytes >> 8;
      burst_nxt.last  = burst_r.last >> 1;
      burst_nxt.count = burst_r.count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= '0;
      burst_r.count <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      st_r          <= st_nxt;
      burst_r.count <= burst_nxt.count;
      out_valid_r   <= out_valid_nxt;
    end
    burst_r.bytes <= burst_nxt.bytes;
    burst_r.last  <= burst_nxt.last;
    out_byte_r    <= out_byte_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
    burst_r.count <= CntW'(BurstMax))
    else $error("burst buffer holds more bytes than a start word can produce");

  a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (burst_r.count <= CntW'(1)))
    else $error("word accepted while earlier bytes would be overwritten");

  a_ident_topic: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.ident_pending |-> (st_r.topic_left != 16'd0))
    else $error("identifier pending with no topic bytes left");

  a_drop_keeps_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (enc_burst.count == '0)) |=> (burst_r.count == '0))
    else $error("dropped data word left bytes in the burst buffer");

endmodule

// ===== bench/mqtt_publish_framer_checker.sv =====
// Checker for the MQTT PUBLISH framer: watches the input and output channels,
// predicts the encoded packet bytes of every accepted word and compares them in order.
// Depends on mpf_pkg for the framing state type, the word actions and the header constant.
module mqtt_publish_framer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [15:0] in_topic_length,
  input  logic [15:0] in_message_length,
  input  logic [1:0]  in_qos,
  input  logic [7:0]  in_data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  output int          errors,
  output int          pending,
  output int          bytes_checked
);
  import mpf_pkg::*;

  localparam logic [1:0] QosTop = 2'd2;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } packet_byte_t;

  frame_state_t framing;
  packet_byte_t packet_bytes_q[$];

  initial begin
    errors = 0;
    pending = 0;
    bytes_checked = 0;
    framing = '0;
  end

  function automatic void queue_byte(input logic [7:0] value, input logic last);
    packet_bytes_q.push_back('{value: value, last: last});
  endfunction

  function automatic void queue_ident();
    logic done;
    done = (framing.message_left == 16'd0);
    queue_byte(framing.packet_ident[15:8], 1'b0);
    queue_byte(framing.packet_ident[7:0], done);
    framing.packet_ident = framing.packet_ident + 16'd1;
    framing.ident_pending = 1'b0;
  endfunction

  function automatic void frame_word(input logic act, input logic [15:0] tlen,
                                     input logic [15:0] mlen, input logic [1:0] qos,
                                     input logic [7:0] din);
    logic [1:0]      level;
    logic [RemW-1:0] remaining;
    logic [7:0]      group;
    if (act == ACT_START) begin
      level = (qos > QosTop) ? QosTop : qos;
      remaining = RemW'(2) + RemW'(tlen) + RemW'(mlen) + ((level != 2'd0) ? RemW'(2) : RemW'(0));
      framing.topic_left = tlen;
      framing.message_left = mlen;
      framing.ident_pending = (level != 2'd0);
      queue_byte(PublishType | {5'd0, level, 1'b0}, 1'b0);
      do begin
        group = {1'b0, remaining[6:0]};
        remaining = remaining / VarintBase;
        if (remaining != '0) group[7] = 1'b1;
        queue_byte(group, 1'b0);
      end while (remaining != '0);
      queue_byte(tlen[15:8], 1'b0);
      queue_byte(tlen[7:0], tlen == 16'd0 && !framing.ident_pending && mlen == 16'd0);
      if (tlen == 16'd0 && framing.ident_pending) queue_ident();
    end else if (framing.topic_left != 16'd0) begin
      framing.topic_left = framing.topic_left - 16'd1;
      queue_byte(din, framing.topic_left == 16'd0 && !framing.ident_pending &&
                      framing.message_left == 16'd0);
      if (framing.topic_left == 16'd0 && framing.ident_pending) queue_ident();
    end else if (framing.message_left != 16'd0) begin
      framing.message_left = framing.message_left - 16'd1;
      queue_byte(din, framing.message_left == 16'd0);
    end
  endfunction

  always @(posedge clk) begin
    packet_byte_t want;
    if (!rst_n) begin
      framing = '0;
      packet_bytes_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (packet_bytes_q.size() == 0) begin
          $error("out_byte %02h with last %0b arrived with no byte expected", out_byte, out_last);
          errors = errors + 1;
        end else begin
          want = packet_bytes_q.pop_front();
          bytes_checked = bytes_checked + 1;
          if (out_byte !== want.value) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want.value, out_byte);
            errors = errors + 1;
          end
          if (out_last !== want.last) begin
            $error("out_last mismatch: expected %0b, actual %0b", want.last, out_last);
            errors = errors + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        frame_word(in_action, in_topic_length, in_message_length, in_qos, in_data_byte);
    end
    pending = packet_bytes_q.size();
  end

endmodule

// ===== bench/mqtt_publish_framer_tb.sv =====
// Top of the MQTT PUBLISH framer testbench: clock, reset, word stimulus and output stalls.
// Instantiates mqtt_publish_framer and mqtt_publish_framer_checker; depends on mpf_pkg.
module mqtt_publish_framer_tb;
  import mpf_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int RandomWords = 410;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [15:0] in_topic_length;
  logic [15:0] in_message_length;
  logic [1:0]  in_qos;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_last;

  int errors;
  int pending;
  int bytes_checked;
  int cycles;
  int start_words;
  int data_words;
  int ignored_words;
  bit gaps_on;

  mqtt_publish_framer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_topic_length   (in_topic_length),
    .in_message_length (in_message_length),
    .in_qos            (in_qos),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last          (out_last)
  );

  mqtt_publish_framer_checker framing_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_topic_length   (in_topic_length),
    .in_message_length (in_message_length),
    .in_qos            (in_qos),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_last          (out_last),
    .errors            (errors),
    .pending           (pending),
    .bytes_checked     (bytes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d bytes still expected.", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int span;
    out_stall = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          out_stall <= 1'b0;
          span = $urandom_range(1, 30);
        end
        4, 5, 6, 7, 8: begin
          out_stall <= 1'b1;
          span = $urandom_range(1, 3);
        end
        default: begin
          out_stall <= 1'b1;
          span = $urandom_range(10, 40);
        end
      endcase
      repeat (span) @(negedge clk);
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(input logic act, input logic [15:0] tlen, input logic [15:0] mlen,
                           input logic [1:0] qos, input logic [7:0] din);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= act;
    in_topic_length   <= tlen;
    in_message_length <= mlen;
    in_qos            <= qos;
    in_data_byte      <= din;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (act == ACT_START) start_words++;
    else data_words++;
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [15:0] tlen, input logic [15:0] mlen,
                             input logic [1:0] qos, input int data_count);
    send_word(ACT_START, tlen, mlen, qos, 8'($urandom));
    for (int i = 0; i < data_count; i++) begin
      if (i >= int'(tlen) + int'(mlen)) ignored_words++;
      send_word(ACT_DATA, 16'($urandom), 16'($urandom), 2'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    int kind;
    int count;
    logic [15:0] tlen;
    logic [15:0] mlen;
    logic [1:0]  qos;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_START;
    in_topic_length = '0;
    in_message_length = '0;
    in_qos = '0;
    in_data_byte = '0;
    start_words = 0;
    data_words = 0;
    ignored_words = 0;
    gaps_on = 1'b1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    send_packet(16'd0, 16'd0, 2'd0, 0);
    send_packet(16'd0, 16'd0, 2'd1, 0);
    send_packet(16'd2, 16'd1, 2'd2, 3);
    send_packet(16'd1, 16'd0, 2'd3, 1);
    send_word(ACT_DATA, 16'hFFFF, 16'hFFFF, 2'd3, 8'hFF);
    send_word(ACT_DATA, 16'h0000, 16'h0000, 2'd0, 8'h00);
    send_packet(16'd3, 16'd2, 2'd1, 1);
    send_packet(16'd0, 16'd1, 2'd0, 1);
    send_packet(16'd125, 16'd0, 2'd0, 0);
    send_packet(16'd126, 16'd0, 2'd0, 0);
    send_packet(16'd16381, 16'd0, 2'd0, 0);
    send_packet(16'd16382, 16'd0, 2'd0, 0);
    send_packet(16'hFFFF, 16'hFFFF, 2'd2, 0);
    send_packet(16'd0, 16'd2, 2'd1, 2);

    while (start_words + data_words - ignored_words < RandomWords) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      kind = $urandom_range(0, 39);
      qos = 2'($urandom_range(0, 3));
      if (kind < 2) begin
        tlen = 16'($urandom);
        mlen = 16'($urandom);
        count = $urandom_range(0, 4);
      end else if (kind == 2) begin
        tlen = 16'($urandom_range(120, 130));
        mlen = 16'($urandom_range(0, 4));
        count = int'(tlen) + int'(mlen);
      end else begin
        tlen = 16'($urandom_range(0, 6));
        mlen = 16'($urandom_range(0, 10));
        count = int'(tlen) + int'(mlen);
        if (kind < 6) count = $urandom_range(0, count);
        else if (kind < 10) count = count + $urandom_range(1, 3);
      end
      send_packet(tlen, mlen, qos, count);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d start words and %0d data words, %0d of them surplus.",
             start_words, data_words, ignored_words);
    $display("Checked %0d packet bytes with %0d mismatches.", bytes_checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
